>>> hw/rtl/sorted_timer_queue_assert.svh
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define STQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/stq_pkg.sv
package stq_pkg;

  localparam int STQ_DEPTH = 32;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [39:0] WAKE_MAX     = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_SCHEDULE = 2'd0,
    ACT_CANCEL   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_SHIFT    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_SHIFT  = 3'd3,
    CMD_POP    = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    logic        vld;
    logic [4:0]  tid;
    logic [31:0] sec;
    logic [19:0] usec;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{vld: 1'b0, tid: 5'd0, sec: 32'd0, usec: 20'd0};

  // broadcast to every slot of the chain
  typedef struct packed {
    cell_cmd_t   cmd;
    logic [4:0]  tid;
    logic [31:0] key_sec;
    logic [19:0] key_usec;
    logic [31:0] add_sec;
  } cell_ctl_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_sum;
  } wake_ctl_t;

endpackage

>>> hw/rtl/sorted_timer_queue.sv
// sorted_timer_queue: up to DEPTH pending tasks kept in due-time order
//
// request channel (in_valid / in_ready): in_action picks schedule, cancel,
// tick or shift; in_task_id, in_delay_* and in_now_* carry its operands.
// one request is worked at a time; in_ready is high only while idle.
// result channel (out_valid / out_ready): schedule, cancel and shift give one
// result, a tick gives one result per fired task (head first) or a single
// result with out_fired low. out_last marks the final result of a request.
// a taken request passes the exec state (a remove pass for a schedule or
// cancel), the insert state for a schedule only, then the wake unit's
// stages, and its first result is offered in the output state. a tick
// gives one more result per extra fired task. the 40-bit wake time goes
// through a two-stage unit (scaled seconds difference, then sum and clamp).
// reset clears every slot valid flag and the pending count: the queue is
// empty and the block is idle. while out_ready is low the result holds
// still and no further request is taken.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int DEPTH = STQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [4:0]  in_task_id,
  input  logic [30:0] in_delay_seconds,
  input  logic [19:0] in_delay_micros,
  input  logic [31:0] in_now_seconds,
  input  logic [19:0] in_now_micros,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fired,
  output logic [4:0]  out_fired_task,
  output logic        out_status,
  output logic        out_last,
  output logic [5:0]  out_pending_count,
  output logic [39:0] out_next_wake_micros
);

  localparam int LW = $clog2(DEPTH + 1);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_INS  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;

  // request registers
  action_t     op_r, op_nxt;
  logic [4:0]  id_r, id_nxt;
  logic [30:0] dsec_r, dsec_nxt;
  logic [19:0] dmic_r, dmic_nxt;
  logic [31:0] ns_r, ns_nxt;
  logic [19:0] nm_r, nm_nxt;

  // computed due time for schedule
  logic [31:0] due_s_r, due_s_nxt;
  logic [19:0] due_m_r, due_m_nxt;

  logic        status_r, status_nxt;
  logic        fired_r, fired_nxt;

  // head after the tick pops, picked before they happen
  logic        src_vld_r, src_vld_nxt;
  logic [31:0] src_s_r, src_s_nxt;
  logic [19:0] src_m_r, src_m_nxt;

  // chain wiring
  entry_t      ent [DEPTH];
  logic [DEPTH:0]   nl_v;
  logic [DEPTH-1:0] rm_v;
  logic [DEPTH-1:0] fnd_v;
  logic [DEPTH-1:0] occ;
  cell_ctl_t   ctl;
  logic        any_match;

  // tick bookkeeping
  logic [LW-1:0] nd;
  entry_t        sel_ent;

  // due-time carry
  logic [20:0] m0, m1, m2;
  logic        c1, c2;
  logic [31:0] s_sum;

  // wake unit hookup
  wake_ctl_t   wctl;
  logic        w_vld;
  logic [31:0] w_sec;
  logic [19:0] w_usec;
  logic [39:0] wake;

  // ---------------------------------------------------------------------
  // the slot chain: each slot holds one entry and trades with neighbors
  // ---------------------------------------------------------------------
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_chain
    entry_t l_ent, r_ent;
    logic   l_nl, l_rm;
    if (gi == 0) begin : g_head
      assign l_ent = ENTRY_EMPTY;
      assign l_nl  = 1'b1;
      assign l_rm  = 1'b0;
    end else begin : g_body
      assign l_ent = ent[gi-1];
      assign l_nl  = nl_v[gi-1];
      assign l_rm  = rm_v[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_tail
      assign r_ent = ENTRY_EMPTY;
    end else begin : g_inner
      assign r_ent = ent[gi+1];
    end

    stq_cell u_slot (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .left_ent_i  (l_ent),
      .left_nl_i   (l_nl),
      .left_rm_i   (l_rm),
      .right_ent_i (r_ent),
      .ent_o       (ent[gi]),
      .nl_o        (nl_v[gi]),
      .rm_o        (rm_v[gi]),
      .first_nd_o  (fnd_v[gi])
    );

    assign occ[gi] = ent[gi].vld;
  end

  assign nl_v[DEPTH] = 1'b0;
  // the remove chain ends high when the task sits anywhere in the queue
  assign any_match   = rm_v[DEPTH-1];

  // ---------------------------------------------------------------------
  // due time = now + delay, microseconds folded back below one second
  // ---------------------------------------------------------------------
  always_comb begin
    m0    = {1'b0, nm_r} + {1'b0, dmic_r};
    c1    = m0 >= {1'b0, USEC_PER_SEC};
    m1    = c1 ? (m0 - {1'b0, USEC_PER_SEC}) : m0;
    c2    = m1 >= {1'b0, USEC_PER_SEC};
    m2    = c2 ? (m1 - {1'b0, USEC_PER_SEC}) : m1;
    s_sum = ns_r + {1'b0, dsec_r} + 32'(c1) + 32'(c2);
  end

  // ---------------------------------------------------------------------
  // tick: due slots form a prefix; count it and pick the first slot left
  // ---------------------------------------------------------------------
  always_comb begin
    nd      = '0;
    sel_ent = ENTRY_EMPTY;
    for (int i = 0; i < DEPTH; i++) begin
      if (nl_v[i] && !nl_v[i+1]) begin
        nd = nd | LW'(i + 1);
      end
      if (fnd_v[i]) begin
        sel_ent = sel_ent | ent[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    dsec_nxt    = dsec_r;
    dmic_nxt    = dmic_r;
    ns_nxt      = ns_r;
    nm_nxt      = nm_r;
    due_s_nxt   = due_s_r;
    due_m_nxt   = due_m_r;
    status_nxt  = status_r;
    fired_nxt   = fired_r;
    src_vld_nxt = src_vld_r;
    src_s_nxt   = src_s_r;
    src_m_nxt   = src_m_r;

    // tick compares slots against now, insert against the due time
    ctl.cmd      = CMD_HOLD;
    ctl.tid      = id_r;
    ctl.key_sec  = (op_r == ACT_TICK) ? ns_r : due_s_r;
    ctl.key_usec = (op_r == ACT_TICK) ? nm_r : due_m_r;
    ctl.add_sec  = {1'b0, dsec_r};

    wctl.ld_mul = 1'b0;
    wctl.ld_sum = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = action_t'(in_action);
          id_nxt     = in_task_id;
          dsec_nxt   = in_delay_seconds;
          dmic_nxt   = in_delay_micros;
          ns_nxt     = in_now_seconds;
          nm_nxt     = in_now_micros;
          status_nxt = 1'b0;
          fired_nxt  = 1'b0;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_r)
          ACT_SCHEDULE: begin
            // a pending task is moved: take it out first
            ctl.cmd   = CMD_REMOVE;
            due_s_nxt = s_sum;
            due_m_nxt = m2[19:0];
            if (any_match) begin
              len_nxt = len_r - LW'(1);
            end
            state_nxt = ST_INS;
          end
          ACT_CANCEL: begin
            ctl.cmd    = CMD_REMOVE;
            status_nxt = !any_match;
            if (any_match) begin
              len_nxt = len_r - LW'(1);
            end
            state_nxt = ST_MUL;
          end
          ACT_TICK: begin
            // slots pop later, one per result handed out
            fired_nxt   = nl_v[0];
            len_nxt     = len_r - nd;
            src_vld_nxt = sel_ent.vld;
            src_s_nxt   = sel_ent.sec;
            src_m_nxt   = sel_ent.usec;
            state_nxt   = ST_MUL;
          end
          default: begin
            ctl.cmd   = CMD_SHIFT;
            state_nxt = ST_MUL;
          end
        endcase
      end
      ST_INS: begin
        // insert after every entry due no later, unless the queue is full
        if (len_r >= LW'(DEPTH)) begin
          status_nxt = 1'b1;
        end else begin
          ctl.cmd = CMD_INSERT;
          len_nxt = len_r + LW'(1);
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        wctl.ld_mul = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        wctl.ld_sum = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (fired_r) begin
            ctl.cmd = CMD_POP;
            if (!nl_v[1]) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    dsec_r    <= dsec_nxt;
    dmic_r    <= dmic_nxt;
    ns_r      <= ns_nxt;
    nm_r      <= nm_nxt;
    due_s_r   <= due_s_nxt;
    due_m_r   <= due_m_nxt;
    status_r  <= status_nxt;
    fired_r   <= fired_nxt;
    src_vld_r <= src_vld_nxt;
    src_s_r   <= src_s_nxt;
    src_m_r   <= src_m_nxt;
  end

  // ---------------------------------------------------------------------
  // wake time: head after the request, measured from now
  // ---------------------------------------------------------------------
  always_comb begin
    if (op_r == ACT_TICK) begin
      w_vld  = src_vld_r;
      w_sec  = src_s_r;
      w_usec = src_m_r;
    end else begin
      w_vld  = ent[0].vld;
      w_sec  = ent[0].sec;
      w_usec = ent[0].usec;
    end
  end

  stq_wake u_wake (
    .clk        (clk),
    .ctl_i      (wctl),
    .src_vld_i  (w_vld),
    .src_sec_i  (w_sec),
    .src_usec_i (w_usec),
    .now_sec_i  (ns_r),
    .now_usec_i (nm_r),
    .wake_o     (wake)
  );

  // ---------------------------------------------------------------------
  // ports
  // ---------------------------------------------------------------------
  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = (state_r == ST_OUT);
  assign out_fired            = fired_r;
  // fired task is the current head; it pops when the result is taken
  assign out_fired_task       = fired_r ? ent[0].tid : 5'd0;
  assign out_status           = status_r;
  assign out_last             = fired_r ? !nl_v[1] : 1'b1;
  assign out_pending_count    = 6'(len_r);
  assign out_next_wake_micros = wake;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `include "sorted_timer_queue_assert.svh"

  `STQ_ASSERT_NOW(a_len_matches_slots, state_r == ST_IDLE, $countones(occ) == len_r, "pending count and occupied slots disagree")
  `STQ_ASSERT_NOW(a_one_side_only, in_ready, !out_valid, "request taken while a result is offered")
  `STQ_ASSERT_NOW(a_fired_head_due, out_valid && out_fired, nl_v[0], "fired result with a head not yet due")
  `STQ_ASSERT_NEXT(a_last_frees_input, out_valid && out_ready && out_last, in_ready, "block not idle after final result")

endmodule

>>> hw/rtl/stq_cell.sv
module stq_cell
  import stq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl_i,
  input  entry_t    left_ent_i,
  input  logic      left_nl_i,
  input  logic      left_rm_i,
  input  entry_t    right_ent_i,
  output entry_t    ent_o,
  output logic      nl_o,
  output logic      rm_o,
  output logic      first_nd_o
);

  entry_t ent_r, ent_nxt;
  entry_t new_ent;
  logic   match;

  // entry due no later than the key
  function automatic logic not_later(input logic [31:0] es, input logic [19:0] em,
                                     input logic [31:0] ks, input logic [19:0] km);
    return (es < ks) || ((es == ks) && (em <= km));
  endfunction

  assign ent_o      = ent_r;
  // due no later, and so is every slot to the left
  assign nl_o       = left_nl_i && ent_r.vld &&
                      not_later(ent_r.sec, ent_r.usec, ctl_i.key_sec, ctl_i.key_usec);
  assign match      = ent_r.vld && (ent_r.tid == ctl_i.tid);
  assign rm_o       = left_rm_i || match;
  assign first_nd_o = ent_r.vld && !nl_o && left_nl_i;

  always_comb begin
    new_ent      = ENTRY_EMPTY;
    new_ent.vld  = 1'b1;
    new_ent.tid  = ctl_i.tid;
    new_ent.sec  = ctl_i.key_sec;
    new_ent.usec = ctl_i.key_usec;
    ent_nxt      = ent_r;
    unique case (ctl_i.cmd)
      CMD_HOLD:   ent_nxt = ent_r;
      CMD_REMOVE: if (rm_o) begin
        ent_nxt = right_ent_i;
      end
      CMD_INSERT: begin
        if (nl_o) begin
          ent_nxt = ent_r;
        end else if (left_nl_i) begin
          ent_nxt = new_ent;
        end else begin
          ent_nxt = left_ent_i;
        end
      end
      CMD_SHIFT:  ent_nxt.sec = ent_r.sec + ctl_i.add_sec;
      CMD_POP:    ent_nxt = right_ent_i;
      default:    ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

>>> hw/rtl/stq_wake.sv
module stq_wake
  import stq_pkg::*;
(
  input  logic        clk,
  input  wake_ctl_t   ctl_i,
  input  logic        src_vld_i,
  input  logic [31:0] src_sec_i,
  input  logic [19:0] src_usec_i,
  input  logic [31:0] now_sec_i,
  input  logic [19:0] now_usec_i,
  output logic [39:0] wake_o
);

  localparam logic signed [20:0] USEC_S     = 21'sd1000000;
  localparam logic signed [53:0] WAKE_MAX_S = 54'(WAKE_MAX);

  logic               empty_r, empty_nxt;
  logic signed [53:0] prod_r, prod_nxt;
  logic signed [20:0] dm_r, dm_nxt;
  logic [39:0]        wake_r, wake_nxt;
  logic signed [32:0] ds;
  logic signed [53:0] tot;

  // stage one: seconds difference scaled to microseconds, and the microseconds difference
  always_comb begin
    ds        = $signed({1'b0, src_sec_i}) - $signed({1'b0, now_sec_i});
    prod_nxt  = ds * USEC_S;
    dm_nxt    = $signed({1'b0, src_usec_i}) - $signed({1'b0, now_usec_i});
    empty_nxt = !src_vld_i;
  end

  // stage two: sum, clamp at zero and at the top; an empty queue gives zero
  always_comb begin
    tot = prod_r + 54'(dm_r);
    if (empty_r || (tot <= 54'sd0)) begin
      wake_nxt = '0;
    end else if (tot > WAKE_MAX_S) begin
      wake_nxt = WAKE_MAX;
    end else begin
      wake_nxt = tot[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.ld_mul) begin
      empty_r <= empty_nxt;
      prod_r  <= prod_nxt;
      dm_r    <= dm_nxt;
    end
    if (ctl_i.ld_sum) begin
      wake_r <= wake_nxt;
    end
  end

  assign wake_o = wake_r;

endmodule
